// ----- rtl/core/spcol_pkg.sv -----
// shared types and constants of the shape pair collision test
package spcol_pkg;

  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [2:0] {
    OP_CC = 3'd0,
    OP_CS = 3'd1,
    OP_CR = 3'd2,
    OP_SS = 3'd3,
    OP_SR = 3'd4,
    OP_RR = 3'd5
  } op_e;

  typedef struct packed {
    logic cc;
    logic cs;
    logic cr;
  } circ_hit_t;

endpackage

// ----- rtl/core/spcol_segx.sv -----
// pipelined segment crossing test, four register stages
module spcol_segx import spcol_pkg::*; #(
  parameter int PtBits = COORD_BITS_DEF + 2
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [PtBits-1:0] ax1_i,
  input  logic signed [PtBits-1:0] ay1_i,
  input  logic signed [PtBits-1:0] ax2_i,
  input  logic signed [PtBits-1:0] ay2_i,
  input  logic signed [PtBits-1:0] bx1_i,
  input  logic signed [PtBits-1:0] by1_i,
  input  logic signed [PtBits-1:0] bx2_i,
  input  logic signed [PtBits-1:0] by2_i,
  output logic                     hit_o
);

  localparam int D = PtBits + 1;
  localparam int P = 2 * D;
  localparam int S = P + 1;

  function automatic logic btw(input logic signed [S-1:0] n, input logic signed [S-1:0] den);
    logic r;
    if (den > 0) begin
      r = (n > 0) && (n < den);
    end else begin
      r = (n > den) && (n < 0);
    end
    return r;
  endfunction

  logic signed [PtBits-1:0] lx, hx, ly, hy;
  logic signed [D-1:0] bdx_d, bdy_d, adx_d, ady_d, ex_d, ey_d;
  logic signed [D-1:0] bdx_q, bdy_q, adx_q, ady_q, ex_q, ey_q;
  logic coll_d;
  logic [2:0] coll_q;
  logic signed [P-1:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  logic signed [S-1:0] den_q, na_q, nb_q;
  logic hit_q;

  always_comb begin
    lx = (ax1_i < ax2_i) ? ax1_i : ax2_i;
    hx = (ax1_i < ax2_i) ? ax2_i : ax1_i;
    ly = (ay1_i < ay2_i) ? ay1_i : ay2_i;
    hy = (ay1_i < ay2_i) ? ay2_i : ay1_i;
    coll_d = (lx <= bx1_i && bx1_i <= hx && ly <= by1_i && by1_i <= hy) ||
             (lx <= bx2_i && bx2_i <= hx && ly <= by2_i && by2_i <= hy);
    bdx_d = D'(bx2_i) - D'(bx1_i);
    bdy_d = D'(by2_i) - D'(by1_i);
    adx_d = D'(ax2_i) - D'(ax1_i);
    ady_d = D'(ay2_i) - D'(ay1_i);
    ex_d  = D'(ax1_i) - D'(bx1_i);
    ey_d  = D'(ay1_i) - D'(by1_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bdx_q  <= bdx_d;
      bdy_q  <= bdy_d;
      adx_q  <= adx_d;
      ady_q  <= ady_d;
      ex_q   <= ex_d;
      ey_q   <= ey_d;
      coll_q <= {coll_q[1:0], coll_d};
      p1_q   <= P'(bdy_q) * P'(adx_q);
      p2_q   <= P'(bdx_q) * P'(ady_q);
      p3_q   <= P'(bdx_q) * P'(ey_q);
      p4_q   <= P'(bdy_q) * P'(ex_q);
      p5_q   <= P'(adx_q) * P'(ey_q);
      p6_q   <= P'(ady_q) * P'(ex_q);
      den_q  <= S'(p1_q) - S'(p2_q);
      na_q   <= S'(p3_q) - S'(p4_q);
      nb_q   <= S'(p5_q) - S'(p6_q);
      // parallel lines only hit when collinear and overlapping
      if (den_q == '0) begin
        hit_q <= (na_q == '0) && (nb_q == '0) && coll_q[2];
      end else begin
        hit_q <= btw(na_q, den_q) && btw(nb_q, den_q);
      end
    end
  end

  assign hit_o = hit_q;

endmodule

// ----- rtl/core/spcol_circ.sv -----
// pipelined circle tests against circle, segment and rectangle
module spcol_circ import spcol_pkg::*; #(
  parameter int CoordBits = COORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [CoordBits-1:0] a0_i,
  input  logic signed [CoordBits-1:0] a1_i,
  input  logic signed [CoordBits-1:0] a2_i,
  input  logic signed [CoordBits-1:0] b0_i,
  input  logic signed [CoordBits-1:0] b1_i,
  input  logic signed [CoordBits-1:0] b2_i,
  input  logic signed [CoordBits-1:0] b3_i,
  input  logic signed [CoordBits:0]   bxw_i,
  input  logic signed [CoordBits:0]   byh_i,
  output circ_hit_t                   hit_o
);

  localparam int C  = CoordBits;
  localparam int D  = C + 2;
  localparam int P  = 2 * D;
  localparam int S  = P + 1;
  localparam int H  = C + 1;
  localparam int W1 = 2 * H;
  localparam int FW = 4 * H;

  // stage 1: differences and clamp
  logic signed [D-1:0] ccdx_d, ccdy_d, ccs_d, crdx_d, crdy_d;
  logic signed [D-1:0] ux_d, uy_d, rx_d, ry_d, qx_d, qy_d;
  logic signed [D-1:0] ccdx_q, ccdy_q, ccs_q, crdx_q, crdy_q, rad_q;
  logic signed [D-1:0] ux_q, uy_q, rx_q, ry_q, qx_q, qy_q;
  // stage 2: products
  logic signed [P-1:0] ccdx2_q, ccdy2_q, ccs2_q, crdx2_q, crdy2_q, r2_q;
  logic signed [P-1:0] rx2_q, ry2_q, qx2_q, qy2_q, ux2_q, uy2_q;
  logic signed [P-1:0] rxux_q, ryuy_q, rxuy_q, ryux_q;
  // stage 3: sums and distance compares
  logic signed [S-1:0] l2_q, dot_q, crs_q;
  logic signed [P-1:0] r2b_q;
  logic [2:0] f4_q;
  // stage 4: projection range and magnitudes
  logic [W1-1:0] cm_q, l2m_q, r2m_q;
  logic [3:0] f5_q, f6_q, f7_q;
  // stage 5: partial products
  logic [2*H-1:0] phh_q, phl_q, pll_q, qhh_q, qhl_q, qlh_q, qll_q;
  // stage 6: assembled wide products
  logic [FW-1:0] lhs_q, rhs_q;
  circ_hit_t hit_q;

  always_comb begin
    ccdx_d = D'(a0_i) - D'(b0_i);
    ccdy_d = D'(a1_i) - D'(b1_i);
    ccs_d  = D'(a2_i) + D'(b2_i);
    if (D'(a0_i) < D'(b0_i)) begin
      crdx_d = D'(a0_i) - D'(b0_i);
    end else if (D'(a0_i) > D'(bxw_i)) begin
      crdx_d = D'(a0_i) - D'(bxw_i);
    end else begin
      crdx_d = '0;
    end
    if (D'(a1_i) < D'(b1_i)) begin
      crdy_d = D'(a1_i) - D'(b1_i);
    end else if (D'(a1_i) > D'(byh_i)) begin
      crdy_d = D'(a1_i) - D'(byh_i);
    end else begin
      crdy_d = '0;
    end
    ux_d = D'(b2_i) - D'(b0_i);
    uy_d = D'(b3_i) - D'(b1_i);
    rx_d = D'(a0_i) - D'(b0_i);
    ry_d = D'(a1_i) - D'(b1_i);
    qx_d = D'(a0_i) - D'(b2_i);
    qy_d = D'(a1_i) - D'(b3_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ccdx_q <= ccdx_d;
      ccdy_q <= ccdy_d;
      ccs_q  <= ccs_d;
      crdx_q <= crdx_d;
      crdy_q <= crdy_d;
      rad_q  <= D'(a2_i);
      ux_q   <= ux_d;
      uy_q   <= uy_d;
      rx_q   <= rx_d;
      ry_q   <= ry_d;
      qx_q   <= qx_d;
      qy_q   <= qy_d;

      ccdx2_q <= P'(ccdx_q) * P'(ccdx_q);
      ccdy2_q <= P'(ccdy_q) * P'(ccdy_q);
      ccs2_q  <= P'(ccs_q) * P'(ccs_q);
      crdx2_q <= P'(crdx_q) * P'(crdx_q);
      crdy2_q <= P'(crdy_q) * P'(crdy_q);
      r2_q    <= P'(rad_q) * P'(rad_q);
      rx2_q   <= P'(rx_q) * P'(rx_q);
      ry2_q   <= P'(ry_q) * P'(ry_q);
      qx2_q   <= P'(qx_q) * P'(qx_q);
      qy2_q   <= P'(qy_q) * P'(qy_q);
      ux2_q   <= P'(ux_q) * P'(ux_q);
      uy2_q   <= P'(uy_q) * P'(uy_q);
      rxux_q  <= P'(rx_q) * P'(ux_q);
      ryuy_q  <= P'(ry_q) * P'(uy_q);
      rxuy_q  <= P'(rx_q) * P'(uy_q);
      ryux_q  <= P'(ry_q) * P'(ux_q);

      // flags: cc hit, cr hit, endpoint strictly inside
      f4_q[2] <= (S'(ccdx2_q) + S'(ccdy2_q)) <= S'(ccs2_q);
      f4_q[1] <= (S'(crdx2_q) + S'(crdy2_q)) <= S'(r2_q);
      f4_q[0] <= ((S'(rx2_q) + S'(ry2_q)) < S'(r2_q)) ||
                 ((S'(qx2_q) + S'(qy2_q)) < S'(r2_q));
      l2_q  <= S'(ux2_q) + S'(uy2_q);
      dot_q <= S'(rxux_q) + S'(ryuy_q);
      crs_q <= S'(rxuy_q) - S'(ryux_q);
      r2b_q <= r2_q;

      // zero length segment or projection outside the segment gives no hit from the distance test
      f5_q  <= {f4_q, (l2_q != '0) && (dot_q >= 0) && (dot_q <= l2_q)};
      cm_q  <= (crs_q < 0) ? W1'(-crs_q) : W1'(crs_q);
      l2m_q <= W1'(l2_q);
      r2m_q <= W1'(r2b_q);

      f6_q  <= f5_q;
      phh_q <= cm_q[W1-1:H] * cm_q[W1-1:H];
      phl_q <= cm_q[W1-1:H] * cm_q[H-1:0];
      pll_q <= cm_q[H-1:0] * cm_q[H-1:0];
      qhh_q <= r2m_q[W1-1:H] * l2m_q[W1-1:H];
      qhl_q <= r2m_q[W1-1:H] * l2m_q[H-1:0];
      qlh_q <= r2m_q[H-1:0] * l2m_q[W1-1:H];
      qll_q <= r2m_q[H-1:0] * l2m_q[H-1:0];

      f7_q  <= f6_q;
      lhs_q <= (FW'(phh_q) << (2 * H)) + (FW'(phl_q) << (H + 1)) + FW'(pll_q);
      rhs_q <= (FW'(qhh_q) << (2 * H)) + (FW'(qhl_q) << H) + (FW'(qlh_q) << H) +
               FW'(qll_q);

      hit_q.cc <= f7_q[3];
      hit_q.cr <= f7_q[2];
      hit_q.cs <= f7_q[1] || (f7_q[0] && (lhs_q <= rhs_q));
    end
  end

  assign hit_o = hit_q;

endmodule

// ----- rtl/core/shape_pair_collision_test.sv -----
// shape pair collision test: top level pipeline and stream ports
// throughput: one pair per cycle while the output is not stalled
// the deepest path is the circle vs segment unit
// a stall on the output freezes every stage, so no beat is lost or repeated
// reset clears the valid bits only; the pipeline is empty after reset
module shape_pair_collision_test import spcol_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // a0, a1, a2, a3, b0, b1, b2, b3 from bit 0 up
  input  logic [8*COORD_BITS-1:0] s_axis_tdata,
  // op
  input  logic [2:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // hit, zero padded
  output logic [7:0]            m_axis_tdata
);

  localparam int C  = COORD_BITS;
  localparam int C1 = C + 1;
  localparam int PW = C + 2;

  logic en;
  logic [8:0] vld_q;
  logic [7:0][2:0] op_q;
  logic signed [C-1:0] a_in [4];
  logic signed [C-1:0] b_in [4];
  logic signed [C-1:0] a_q [4];
  logic signed [C-1:0] b_q [4];
  logic signed [C1-1:0] axw_q, ayh_q, bxw_q, byh_q;
  logic signed [PW-1:0] xr_q, yb_q;
  logic [6:0] rr_q;
  logic [3:0] ic_q;
  logic [2:0] ss_q, sr_q;
  logic ss_hit, e0_hit, e1_hit, e2_hit, e3_hit;
  circ_hit_t circ_hit;
  logic hit_q;

  assign en            = !vld_q[8] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[8];
  assign m_axis_tdata  = {7'd0, hit_q};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a_in[k] = s_axis_tdata[k*C +: C];
      b_in[k] = s_axis_tdata[(k+4)*C +: C];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[7:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_q <= {op_q[6:0], s_axis_tuser};
      for (int k = 0; k < 4; k++) begin
        a_q[k] <= a_in[k];
        b_q[k] <= b_in[k];
      end
      axw_q <= C1'(a_in[0]) + C1'(a_in[2]);
      ayh_q <= C1'(a_in[1]) + C1'(a_in[3]);
      bxw_q <= C1'(b_in[0]) + C1'(b_in[2]);
      byh_q <= C1'(b_in[1]) + C1'(b_in[3]);
      xr_q  <= PW'(b_in[0]) + PW'(b_in[2]) - PW'(1);
      yb_q  <= PW'(b_in[1]) + PW'(b_in[3]) - PW'(1);

      rr_q <= {rr_q[5:0],
               !((C1'(a_q[0]) >= bxw_q) || (C1'(a_q[1]) >= byh_q) ||
                 (C1'(b_q[0]) >= axw_q) || (C1'(b_q[1]) >= ayh_q))};
      // segment endpoint inside the rect cells
      ic_q <= {ic_q[2:0],
               (b_q[0] <= a_q[0] && PW'(a_q[0]) <= xr_q &&
                b_q[1] <= a_q[1] && PW'(a_q[1]) <= yb_q) ||
               (b_q[0] <= a_q[2] && PW'(a_q[2]) <= xr_q &&
                b_q[1] <= a_q[3] && PW'(a_q[3]) <= yb_q)};
      ss_q <= {ss_q[1:0], ss_hit};
      sr_q <= {sr_q[1:0], ic_q[3] || e0_hit || e1_hit || e2_hit || e3_hit};

      unique case (op_q[7])
        OP_CC:   hit_q <= circ_hit.cc;
        OP_CS:   hit_q <= circ_hit.cs;
        OP_CR:   hit_q <= circ_hit.cr;
        OP_SS:   hit_q <= ss_q[2];
        OP_SR:   hit_q <= sr_q[2];
        OP_RR:   hit_q <= rr_q[6];
        default: hit_q <= 1'b0;
      endcase
    end
  end

  spcol_circ #(.CoordBits(C)) u_circ (
    .clk_i (clk_i),
    .en_i  (en),
    .a0_i  (a_q[0]),
    .a1_i  (a_q[1]),
    .a2_i  (a_q[2]),
    .b0_i  (b_q[0]),
    .b1_i  (b_q[1]),
    .b2_i  (b_q[2]),
    .b3_i  (b_q[3]),
    .bxw_i (bxw_q),
    .byh_i (byh_q),
    .hit_o (circ_hit)
  );

  spcol_segx #(.PtBits(PW)) u_ss (
    .clk_i (clk_i), .en_i (en),
    .ax1_i (PW'(a_q[0])), .ay1_i (PW'(a_q[1])),
    .ax2_i (PW'(a_q[2])), .ay2_i (PW'(a_q[3])),
    .bx1_i (PW'(b_q[0])), .by1_i (PW'(b_q[1])),
    .bx2_i (PW'(b_q[2])), .by2_i (PW'(b_q[3])),
    .hit_o (ss_hit)
  );

  // four inset edges of the rect: top, left, right, bottom
  spcol_segx #(.PtBits(PW)) u_e0 (
    .clk_i (clk_i), .en_i (en),
    .ax1_i (PW'(a_q[0])), .ay1_i (PW'(a_q[1])),
    .ax2_i (PW'(a_q[2])), .ay2_i (PW'(a_q[3])),
    .bx1_i (PW'(b_q[0])), .by1_i (PW'(b_q[1])),
    .bx2_i (xr_q),        .by2_i (PW'(b_q[1])),
    .hit_o (e0_hit)
  );

  spcol_segx #(.PtBits(PW)) u_e1 (
    .clk_i (clk_i), .en_i (en),
    .ax1_i (PW'(a_q[0])), .ay1_i (PW'(a_q[1])),
    .ax2_i (PW'(a_q[2])), .ay2_i (PW'(a_q[3])),
    .bx1_i (PW'(b_q[0])), .by1_i (PW'(b_q[1])),
    .bx2_i (PW'(b_q[0])), .by2_i (yb_q),
    .hit_o (e1_hit)
  );

  spcol_segx #(.PtBits(PW)) u_e2 (
    .clk_i (clk_i), .en_i (en),
    .ax1_i (PW'(a_q[0])), .ay1_i (PW'(a_q[1])),
    .ax2_i (PW'(a_q[2])), .ay2_i (PW'(a_q[3])),
    .bx1_i (xr_q),        .by1_i (PW'(b_q[1])),
    .bx2_i (xr_q),        .by2_i (yb_q),
    .hit_o (e2_hit)
  );

  spcol_segx #(.PtBits(PW)) u_e3 (
    .clk_i (clk_i), .en_i (en),
    .ax1_i (PW'(a_q[0])), .ay1_i (PW'(a_q[1])),
    .ax2_i (PW'(a_q[2])), .ay2_i (PW'(a_q[3])),
    .bx1_i (PW'(b_q[0])), .by1_i (yb_q),
    .bx2_i (xr_q),        .by2_i (yb_q),
    .hit_o (e3_hit)
  );

endmodule

// ----- rtl/core/spcol_chk.sv -----
// port level checks of the shape pair collision test, bound to the top level
module spcol_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // a held result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // input side only stalls when the output side does
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
    else $error("result padding not zero");

endmodule

bind shape_pair_collision_test spcol_chk u_spcol_chk (.*);

// ----- dv/testbench.sv -----
// stream testbench for the shape pair collision test
`timescale 1ns / 100ps

module testbench;
  import spcol_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int LATENCY = 9;

  typedef struct {
    logic [2:0]    kind;
    logic [CB-1:0] f[8];
    int            hit_fixed; // -1 when the predictor decides
  } pair_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [8*CB-1:0] s_axis_tdata = '0;
  logic [2:0]      s_axis_tuser = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [7:0]      m_axis_tdata;

  shape_pair_collision_test #(.COORD_BITS(CB)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic     hit_queue[$];
  int       errors = 0;
  int       sent = 0;
  int       got = 0;
  int       hits_seen = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       hold_recv = 1'b0;
  int       kind_count[8];

  // exact integer predictor, all products fit in 64 bits except the cross test
  function automatic bit seg_cross(longint ax1, longint ay1, longint ax2, longint ay2,
                                   longint bx1, longint by1, longint bx2, longint by2);
    longint den, na, nb, lx, ly, hx, hy;
    den = (by2 - by1) * (ax2 - ax1) - (bx2 - bx1) * (ay2 - ay1);
    na = (bx2 - bx1) * (ay1 - by1) - (by2 - by1) * (ax1 - bx1);
    nb = (ax2 - ax1) * (ay1 - by1) - (ay2 - ay1) * (ax1 - bx1);
    if (den == 0) begin
      if (na != 0 || nb != 0) return 1'b0;
      lx = ax1 < ax2 ? ax1 : ax2;
      hx = ax1 < ax2 ? ax2 : ax1;
      ly = ay1 < ay2 ? ay1 : ay2;
      hy = ay1 < ay2 ? ay2 : ay1;
      return (lx <= bx1 && bx1 <= hx && ly <= by1 && by1 <= hy) ||
             (lx <= bx2 && bx2 <= hx && ly <= by2 && by2 <= hy);
    end
    if (den > 0) return (na > 0 && na < den) && (nb > 0 && nb < den);
    return (na < 0 && na > den) && (nb < 0 && nb > den);
  endfunction

  function automatic bit predict_hit(logic [2:0] kind, logic [CB-1:0] f[8]);
    longint v[8];
    longint ux, uy, rx, ry, qx, qy, r2, l2, d, cr, px, py, dx, dy, s, xr, yb;
    logic signed [127:0] lhs, rhs;
    for (int i = 0; i < 8; i++) v[i] = longint'($signed(f[i]));
    case (kind)
      OP_CC: begin
        dx = v[0] - v[4]; dy = v[1] - v[5]; s = v[2] + v[6];
        return dx * dx + dy * dy <= s * s;
      end
      OP_CS: begin
        ux = v[6] - v[4]; uy = v[7] - v[5];
        rx = v[0] - v[4]; ry = v[1] - v[5];
        qx = v[0] - v[6]; qy = v[1] - v[7];
        r2 = v[2] * v[2];
        l2 = ux * ux + uy * uy;
        if (rx * rx + ry * ry < r2 || qx * qx + qy * qy < r2) return 1'b1;
        if (l2 == 0) return 1'b0;
        d = rx * ux + ry * uy;
        if (d < 0 || d > l2) return 1'b0;
        cr = rx * uy - ry * ux;
        lhs = 128'(cr) * 128'(cr);
        rhs = 128'(r2) * 128'(l2);
        return lhs <= rhs;
      end
      OP_CR: begin
        px = v[0]; py = v[1];
        if (v[0] < v[4]) px = v[4];
        else if (v[0] > v[4] + v[6]) px = v[4] + v[6];
        if (v[1] < v[5]) py = v[5];
        else if (v[1] > v[5] + v[7]) py = v[5] + v[7];
        dx = v[0] - px; dy = v[1] - py;
        return dx * dx + dy * dy <= v[2] * v[2];
      end
      OP_SS: return seg_cross(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
      OP_SR: begin
        xr = v[4] + v[6] - 1; yb = v[5] + v[7] - 1;
        if (v[4] <= v[0] && v[0] <= xr && v[5] <= v[1] && v[1] <= yb) return 1'b1;
        if (v[4] <= v[2] && v[2] <= xr && v[5] <= v[3] && v[3] <= yb) return 1'b1;
        return seg_cross(v[0], v[1], v[2], v[3], v[4], v[5], xr, v[5]) ||
               seg_cross(v[0], v[1], v[2], v[3], v[4], v[5], v[4], yb) ||
               seg_cross(v[0], v[1], v[2], v[3], xr, v[5], xr, yb) ||
               seg_cross(v[0], v[1], v[2], v[3], v[4], yb, xr, yb);
      end
      OP_RR: return !(v[0] >= v[4] + v[6] || v[1] >= v[5] + v[7] ||
                      v[4] >= v[0] + v[2] || v[5] >= v[1] + v[3]);
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_pair(pair_row_t row);
    bit expected;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    expected = predict_hit(row.kind, row.f);
    if (row.hit_fixed >= 0 && expected != row.hit_fixed[0]) begin
      $error("table row disagrees: hit expected %0d, predictor %0d",
             row.hit_fixed, expected);
      errors++;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= row.kind;
    for (int i = 0; i < 8; i++) s_axis_tdata[i*CB +: CB] <= row.f[i];
    do @(posedge clk_i); while (!s_axis_tready);
    hit_queue.push_back(row.hit_fixed >= 0 ? row.hit_fixed[0] : expected);
    kind_count[row.kind]++;
    sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  function automatic pair_row_t make_row(logic [2:0] kind, int f0, int f1, int f2, int f3,
                                         int f4, int f5, int f6, int f7, int h);
    pair_row_t r;
    r.kind = kind;
    r.f[0] = CB'(f0); r.f[1] = CB'(f1); r.f[2] = CB'(f2); r.f[3] = CB'(f3);
    r.f[4] = CB'(f4); r.f[5] = CB'(f5); r.f[6] = CB'(f6); r.f[7] = CB'(f7);
    r.hit_fixed = h;
    return r;
  endfunction

  // random coordinate: mostly small so shapes meet, sometimes full range
  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(9))
      0, 1:    return CB'($urandom);
      2:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return CB'($signed($urandom_range(80)) - 40);
    endcase
  endfunction

  function automatic pair_row_t rand_row();
    pair_row_t r;
    int pick;
    pick = $urandom_range(99);
    r.kind = pick < 97 ? 3'($urandom_range(5)) : 3'($urandom_range(7, 6));
    for (int i = 0; i < 8; i++) r.f[i] = rand_coord();
    // collinear and touching cases by copying endpoints
    if ((r.kind == OP_SS || r.kind == OP_CS) && $urandom_range(4) == 0) begin
      r.f[4] = r.f[0]; r.f[5] = r.f[1];
    end
    if (r.kind == OP_SS && $urandom_range(5) == 0) begin
      r.f[6] = r.f[2] + (r.f[2] - r.f[0]); r.f[7] = r.f[3] + (r.f[3] - r.f[1]);
    end
    r.hit_fixed = -1;
    return r;
  endfunction

  // result side
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (hit_queue.size() == 0) begin
        $error("result beat with nothing expected: hit %0d", m_axis_tdata[0]);
        errors++;
      end else begin
        automatic logic exp_hit = hit_queue.pop_front();
        if (m_axis_tdata[0] !== exp_hit || m_axis_tdata[7:1] !== 7'd0) begin
          $error("hit mismatch: expected %0d, actual %0d (tdata %h)",
                 exp_hit, m_axis_tdata[0], m_axis_tdata);
          errors++;
        end
        got++;
        hits_seen += exp_hit;
      end
    end
    m_axis_tready <= !hold_recv &&
                     !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  initial begin
    pair_row_t rows[$];
    int        burst;
    rows.push_back(make_row(OP_CC, 0, 0, 5, 0, 3, 4, 0, 0, 1));
    rows.push_back(make_row(OP_CC, 0, 0, 2, 0, 3, 4, 2, 0, 0));
    rows.push_back(make_row(OP_CC, -32768, -32768, 32767, 0, 32767, 32767, 32767, 0, 0));
    rows.push_back(make_row(OP_CC, 0, 0, -3, 0, 1, 0, -3, 0, 1));
    rows.push_back(make_row(OP_CS, 0, 0, 2, 0, 1, 0, 10, 0, 1));
    rows.push_back(make_row(OP_CS, 0, 5, 3, 0, -10, 0, 10, 0, 0));
    rows.push_back(make_row(OP_CS, 0, 3, 3, 0, -10, 0, 10, 0, 1));
    rows.push_back(make_row(OP_CS, 0, 0, 3, 0, 10, 10, 10, 10, 0));
    rows.push_back(make_row(OP_CS, -32768, 32767, -32768, 0, 32767, -32768,
                            -32768, 32767, -1));
    rows.push_back(make_row(OP_CR, 0, 0, 1, 0, 1, 0, 5, 5, 1));
    rows.push_back(make_row(OP_CR, 0, 0, 1, 0, 2, 2, 5, 5, 0));
    rows.push_back(make_row(OP_CR, 0, 0, 2, 0, 3, 3, -6, -6, -1));
    rows.push_back(make_row(OP_SS, 0, 0, 10, 10, 0, 10, 10, 0, 1));
    rows.push_back(make_row(OP_SS, 0, 0, 10, 0, 0, 5, 10, 5, 0));
    rows.push_back(make_row(OP_SS, 0, 0, 10, 0, 5, 0, 20, 0, 1));
    rows.push_back(make_row(OP_SS, 0, 0, 10, 0, 11, 0, 20, 0, 0));
    rows.push_back(make_row(OP_SS, 0, 0, 10, 10, 10, 10, 20, 0, 0));
    rows.push_back(make_row(OP_SS, -32768, -32768, 32767, 32767, -32768, 32767,
                            32767, -32768, 1));
    rows.push_back(make_row(OP_SR, 1, 1, 50, 50, 0, 0, 4, 4, 1));
    rows.push_back(make_row(OP_SR, -5, 2, 10, 2, 0, 0, 4, 4, 1));
    rows.push_back(make_row(OP_SR, 10, 10, 20, 20, 0, 0, 4, 4, 0));
    rows.push_back(make_row(OP_RR, 0, 0, 4, 4, 3, 3, 4, 4, 1));
    rows.push_back(make_row(OP_RR, 0, 0, 4, 4, 4, 0, 4, 4, 0));
    rows.push_back(make_row(OP_RR, 0, 0, -4, 4, -2, 0, 4, 4, -1));
    rows.push_back(make_row(3'd6, 0, 0, 5, 5, 0, 0, 5, 5, 0));
    rows.push_back(make_row(3'd7, -1, -1, -1, -1, -1, -1, -1, -1, 0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_pair(rows[i]);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? (phase == 3 ? 26 : 53) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 26 : 53) : 0;
      for (int n = 0; n < 390; n++) send_pair(rand_row());
      // sender waits for every result before going on
      drain_results();
    end

    // long receiver hold-off while the sender keeps pushing
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_recv = 1'b1;
        repeat (60) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      begin
        burst = 40;
        for (int n = 0; n < burst; n++) send_pair(rand_row());
      end
    join
    drain_results();
  end

  initial begin
    wait (sent > 1600);
    wait (hit_queue.size() == 0 && !hold_recv && s_axis_tvalid == 1'b0);
    repeat (LATENCY * 4) @(posedge clk_i);
    $display("%0d pairs sent, %0d results checked, %0d hits, long output hold-off included",
             sent, got, hits_seen);
    $display("per kind 0..7: %0d %0d %0d %0d %0d %0d %0d %0d over idle and stall mixes",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3],
             kind_count[4], kind_count[5], kind_count[6], kind_count[7]);
    if (errors == 0 && hit_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
